/* rtl/tbu_pkg.sv */
`default_nettype none
package tbu_pkg;
    localparam int LANE_W = 16;
    localparam int ENT_W  = 16;
    localparam int ACC_W  = 36;
    localparam int NUM_W  = 44;

    typedef struct packed {
        logic [63:0] row0;
        logic [63:0] row1;
        logic [63:0] row2;
        logic [63:0] row3;
        logic [47:0] bmin;
        logic [47:0] bmax;
        logic        mesh;
        logic        last;
    } t_part;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORNER, ST_DIV, ST_MERGE, ST_EMIT
    } t_state;

    localparam int PART_W = $bits(t_part);
endpackage
`default_nettype wire

/* rtl/tbu_fifo.sv */
`default_nettype none
module tbu_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    // two-entry queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, (i_push && !o_full)} - {1'b0, (i_pop && !o_empty)};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
endmodule
`default_nettype wire

/* rtl/tbu_div.sv */
`default_nettype none
module tbu_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [tbu_pkg::NUM_W-1:0] i_num,
    input  wire logic [tbu_pkg::ACC_W-1:0] i_den,
    output logic                          o_done,
    output logic [tbu_pkg::NUM_W-1:0]     o_quo
);
    import tbu_pkg::*;
    // restoring divide, one quotient bit per cycle, magnitudes
    logic [NUM_W-1:0] r_q, n_q;
    logic [ACC_W:0]   r_rem, n_rem;
    logic [ACC_W-1:0] r_d;
    logic [5:0]       r_cnt;
    logic             r_busy, r_neg;
    logic [ACC_W:0]   w_try;

    always_comb begin
        w_try = {r_rem[ACC_W-1:0], r_q[NUM_W-1]};
        n_q   = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_d}) begin
            n_rem = w_try - {1'b0, r_d};
            n_q[0] = 1'b1;
        end
    end

    assign o_quo = r_neg ? (~r_q + 1'b1) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
            r_d   <= i_den[ACC_W-1] ? (~i_den + 1'b1) : i_den;
            r_neg <= i_num[NUM_W-1] ^ i_den[ACC_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !r_busy)
        else $error("divider done while busy");
endmodule
`default_nettype wire

/* rtl/tbu_back.sv */
`default_nettype none
module tbu_back #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_avail,
    input  wire tbu_pkg::t_part             i_part,
    output logic                            o_take,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [47:0]                     o_min,
    output logic [47:0]                     o_max,
    output logic                            o_any
);
    import tbu_pkg::*;
    localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'((1 << (COORD_WIDTH-1)) - 1);
    localparam logic signed [NUM_W-1:0] SAT_LO = -SAT_HI - NUM_W'(1);

    t_state r_st, n_st;
    logic [2:0] r_corner;
    logic [1:0] r_axis, r_term;
    logic signed [ACC_W-1:0] r_acc [4];
    logic signed [COORD_WIDTH-1:0] r_pmin [3], r_pmax [3], r_rmin [3], r_rmax [3];
    logic r_seen;
    logic r_have_div;
    logic signed [31:0] r_prod;
    logic [1:0] r_prow;
    logic r_pvalid;

    // corner point
    logic signed [COORD_WIDTH-1:0] w_p [3];
    logic signed [ENT_W-1:0] w_m;
    logic signed [LANE_W:0] w_x;
    logic [63:0] w_row;
    always_comb begin
        for (int k = 0; k < 3; k++)
            w_p[k] = r_corner[k] ? COORD_WIDTH'(i_part.bmax[16*k +: 16])
                                 : COORD_WIDTH'(i_part.bmin[16*k +: 16]);
        case (r_axis)
            2'd0: w_row = i_part.row0;
            2'd1: w_row = i_part.row1;
            2'd2: w_row = i_part.row2;
            default: w_row = i_part.row3;
        endcase
        w_m = w_row[16*r_term +: 16];
        if (r_term == 2'd3) w_x = (LANE_W+1)'(256);
        else w_x = (LANE_W+1)'(w_p[r_term]);
    end

    // divide stage
    logic w_div_done;
    logic [NUM_W-1:0] w_quo;
    logic r_div_go;
    logic [1:0] r_daxis;
    logic signed [NUM_W-1:0] w_q, w_sat;
    logic w_axis_ok;
    tbu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num({r_acc[r_daxis], 8'd0}), .i_den(r_acc[3]),
        .o_done(w_div_done), .o_quo(w_quo)
    );
    always_comb begin
        if (r_acc[3] == '0) w_q = NUM_W'(r_acc[r_daxis] / 4096);
        else w_q = w_quo;
        w_sat = (w_q > SAT_HI) ? SAT_HI : ((w_q < SAT_LO) ? SAT_LO : w_q);
    end

    // a done pulse left over from an abandoned divide is ignored on the start cycle
    assign w_axis_ok = (r_acc[3] == '0) ? r_have_div : (w_div_done && !r_div_go);

    logic w_mac_end;
    assign w_mac_end = (r_axis == 2'd3) && (r_term == 2'd3);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_avail) n_st = i_part.mesh ? ST_CORNER : ST_MERGE;
            ST_CORNER: if (r_pvalid && r_prow == 2'd3 && !w_mac_end &&
                           r_term == 2'd0 && r_axis == 2'd0) n_st = ST_DIV;
            ST_DIV: if (w_axis_ok && r_daxis == 2'd2)
                n_st = (r_corner == 3'd7) ? ST_MERGE : ST_CORNER;
            ST_MERGE: n_st = i_part.last ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_take  = ((r_st == ST_MERGE) && !i_part.last) || ((r_st == ST_EMIT) && i_ready);
        o_valid = (r_st == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_seen <= 1'b0;
            r_pvalid <= 1'b0;
            r_div_go <= 1'b0;
            r_have_div <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_rmin[k] <= '0;
                r_rmax[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_div_go <= 1'b0;
            r_have_div <= 1'b0;
            r_pvalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    r_corner <= '0;
                    r_axis <= '0;
                    r_term <= '0;
                    for (int r = 0; r < 4; r++) r_acc[r] <= '0;
                end
                ST_CORNER: begin
                    // 16 products, one a cycle, one stage of register after multiply
                    if (!(r_axis == 2'd0 && r_term == 2'd0 && r_pvalid && r_prow == 2'd3)) begin
                        r_prod <= 32'(w_m) * 32'(w_x);
                        r_prow <= r_axis;
                        r_pvalid <= 1'b1;
                        {r_axis, r_term} <= {r_axis, r_term} + 4'd1;
                    end
                    if (r_pvalid) r_acc[r_prow] <= r_acc[r_prow] + ACC_W'(r_prod);
                    if (n_st == ST_DIV) begin
                        r_daxis <= 2'd0;
                        r_div_go <= 1'b1;
                        r_have_div <= 1'b1;
                    end
                end
                ST_DIV: if (w_axis_ok) begin
                    for (int k = 0; k < 3; k++) if (r_daxis == 2'(k)) begin
                        if (r_corner == 3'd0 || w_sat < NUM_W'(r_pmin[k]))
                            r_pmin[k] <= COORD_WIDTH'(w_sat);
                        if (r_corner == 3'd0 || w_sat > NUM_W'(r_pmax[k]))
                            r_pmax[k] <= COORD_WIDTH'(w_sat);
                    end
                    if (r_daxis != 2'd2) begin
                        r_daxis <= r_daxis + 2'd1;
                        r_div_go <= 1'b1;
                        r_have_div <= 1'b1;
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        for (int r = 0; r < 4; r++) r_acc[r] <= '0;
                    end
                end
                ST_MERGE: begin
                    if (i_part.mesh) begin
                        for (int k = 0; k < 3; k++) begin
                            if (!r_seen || r_pmin[k] < r_rmin[k]) r_rmin[k] <= r_pmin[k];
                            if (!r_seen || r_pmax[k] > r_rmax[k]) r_rmax[k] <= r_pmax[k];
                        end
                        r_seen <= 1'b1;
                    end
                end
                ST_EMIT: if (i_ready) begin
                    r_seen <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_rmin[k] <= '0;
                        r_rmax[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_min[16*k +: 16] = 16'($signed(r_rmin[k]));
            o_max[16*k +: 16] = 16'($signed(r_rmax[k]));
        end
        o_any = r_seen;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_rmin[0] == '0 && r_rmax[0] == '0)) else $error("state not clear");
endmodule
`default_nettype wire

/* rtl/transformed_box_union.sv */
`default_nettype none
// channel  | dir | tdata fields                         | tuser
// s_axis   | in  | row0,row1,row2,row3,box_min,box_max  | has_mesh (tlast=last)
// m_axis   | out | world_min, world_max                 | any_valid
// A contributing part takes 8 corners, each a MAC pass and then 3 divides,
// paced by the single multiplier and the shared bit-serial divider; a corner
// with w zero divides by 4096 instead of waiting for the divider.
// A part without a mesh skips the corner work and goes straight to the merge.
// A two-entry queue between intake and engine takes parts while one is in work.
// Reset (i_rst_n low, synchronous) clears the running box and the queue.
// A stalled result holds; the engine waits until it is taken.
module transformed_box_union #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [351:0] s_axis_tdata,  // row0,row1,row2,row3,box_min,box_max
    input  wire logic         s_axis_tuser,  // has_mesh
    input  wire logic         s_axis_tlast,  // last
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // world_min, world_max
    output logic              m_axis_tuser   // any_valid
);
    import tbu_pkg::*;
    t_part w_in, w_q;
    logic w_full, w_empty, w_take;

    always_comb begin
        w_in.row0 = s_axis_tdata[63:0];
        w_in.row1 = s_axis_tdata[127:64];
        w_in.row2 = s_axis_tdata[191:128];
        w_in.row3 = s_axis_tdata[255:192];
        w_in.bmin = s_axis_tdata[303:256];
        w_in.bmax = s_axis_tdata[351:304];
        w_in.mesh = s_axis_tuser;
        w_in.last = s_axis_tlast;
    end
    assign s_axis_tready = !w_full;

    tbu_fifo #(.WIDTH(PART_W)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_data(w_in), .o_full(w_full),
        .i_pop(w_take), .o_empty(w_empty), .o_data(w_q)
    );

    tbu_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_avail(!w_empty), .i_part(w_q), .o_take(w_take),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_min(m_axis_tdata[47:0]), .o_max(m_axis_tdata[95:48]),
        .o_any(m_axis_tuser)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule
`default_nettype wire
